### design/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ALE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// antecedent in this cycle implies consequent in the next
`define ALE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### design/ale_pkg.sv
// shared types and constants of the linked list engine
package ale_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [2:0] OP_INSERT  = 3'd0;
	localparam logic [2:0] OP_GET     = 3'd1;
	localparam logic [2:0] OP_REMOVE  = 3'd2;
	localparam logic [2:0] OP_ROT_FWD = 3'd3;
	localparam logic [2:0] OP_ROT_BWD = 3'd4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} st_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_WALK_INIT,
		CMD_WALK_STEP,
		CMD_RD_CUR,
		CMD_GET,
		CMD_INS_EMPTY,
		CMD_INS_A,
		CMD_INS_B,
		CMD_REM_A,
		CMD_REM_B,
		CMD_REM_C,
		CMD_REM_D,
		CMD_ROT,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic       chk_ok;
		logic [2:0] op;
		logic       cnt_zero;
		logic       dist_zero;
		logic       rem_last;
	} sts_t;

endpackage

### design/ale_ctrl.sv
// controller state machine sequencing walks and link updates
module ale_ctrl
	import ale_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_WINIT, S_WALK, S_RD, S_GET, S_INS_E, S_INS_A, S_INS_B,
		S_REM_A, S_REM_B, S_REM_C, S_REM_D, S_ROT, S_FIN
	} state_t;

	state_t state_q, after_walk, after_rd;
	logic   out_vld_q;
	logic   fin_go;

	// where to go once the walk has found its slot
	always_comb begin
		case (sts.op)
			OP_INSERT:  after_walk = sts.cnt_zero ? S_INS_E : S_RD;
			OP_GET:     after_walk = S_RD;
			OP_REMOVE:  after_walk = S_RD;
			default:    after_walk = S_ROT;
		endcase
		case (sts.op)
			OP_INSERT: after_rd = S_INS_A;
			OP_GET:    after_rd = S_GET;
			default:   after_rd = S_REM_A;
		endcase
	end

	assign fin_go    = (state_q == S_FIN) && (!out_vld_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;

	// command decode
	always_comb begin
		case (state_q)
			S_IDLE:  cmd = in_valid ? CMD_LOAD : CMD_NONE;
			S_WINIT: cmd = sts.chk_ok ? CMD_WALK_INIT : CMD_NONE;
			S_WALK:  cmd = CMD_WALK_STEP;
			S_RD:    cmd = CMD_RD_CUR;
			S_GET:   cmd = CMD_GET;
			S_INS_E: cmd = CMD_INS_EMPTY;
			S_INS_A: cmd = CMD_INS_A;
			S_INS_B: cmd = CMD_INS_B;
			S_REM_A: cmd = CMD_REM_A;
			S_REM_B: cmd = CMD_REM_B;
			S_REM_C: cmd = CMD_REM_C;
			S_REM_D: cmd = CMD_REM_D;
			S_ROT:   cmd = CMD_ROT;
			S_FIN:   cmd = fin_go ? CMD_FINISH : CMD_NONE;
			default: cmd = CMD_NONE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (fin_go)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_WINIT;
				S_WINIT: begin
					if (!sts.chk_ok)
						state_q <= S_FIN;
					else if (sts.dist_zero)
						state_q <= after_walk;
					else
						state_q <= S_WALK;
				end
				S_WALK:  if (sts.rem_last) state_q <= after_walk;
				S_RD:    state_q <= after_rd;
				S_INS_A: state_q <= S_INS_B;
				S_REM_A: state_q <= S_REM_B;
				S_REM_B: state_q <= S_REM_C;
				S_REM_C: state_q <= S_REM_D;
				S_GET, S_INS_E, S_INS_B, S_REM_D, S_ROT: state_q <= S_FIN;
				S_FIN:   if (fin_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"

	`ALE_ASSERT_NEXT(a_fin_sets_valid, fin_go, out_vld_q)
	`ALE_ASSERT(a_no_accept_busy, !(in_ready && (state_q != S_IDLE)))
	`ALE_ASSERT(a_fin_needs_room, !(fin_go && out_vld_q && !out_ready))

endmodule

### design/ale_dp.sv
// datapath: link and element memories, head, count and walk registers
module ale_dp
	import ale_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [2:0]  op,
	input  logic [8:0]  position,
	input  logic [31:0] value,
	input  logic [7:0]  steps,
	output logic [31:0] data,
	output logic [1:0]  status,
	output logic [8:0]  count,
	output logic        is_empty,
	output logic        is_full
);

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CW     = ((CNT_W > 9) ? CNT_W : 9) + 1;

	logic [DATA_WIDTH-1:0] el_mem [CAPACITY];
	logic [SLOT_W-1:0]     nx_mem [CAPACITY];
	logic [SLOT_W-1:0]     pv_mem [CAPACITY];

	logic [DATA_WIDTH-1:0] el_rd_q, val_q, res_q;
	logic [SLOT_W-1:0]     nx_rd_q, pv_rd_q;
	logic [SLOT_W-1:0]     head_q, cur_q, p_q, nl_q, pl_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CW-1:0]         dist_q, rem_q;
	logic                  fwd_q, pos_zero_q;
	logic [2:0]            op_q;
	st_t                   chk_q, chk_d;

	logic [CW-1:0]         pos_x, cnt_x, half_x, dist_d;
	logic                  fwd_d;
	logic [SLOT_W-1:0]     link_sel, n_slot, last_m1, last_slot, h1, ra;
	logic                  rd_en;
	logic                  el_we, nx_we, pv_we;
	logic [SLOT_W-1:0]     el_wa, nx_wa, pv_wa, nx_wd, pv_wd, nl_d, pl_d;
	logic [DATA_WIDTH-1:0] el_wd;

	// item checks and walk distance
	always_comb begin
		pos_x  = CW'(position);
		cnt_x  = CW'(cnt_q);
		half_x = cnt_x >> 1;
		fwd_d  = (pos_x <= half_x);
		dist_d = fwd_d ? pos_x : (cnt_x - pos_x);
		case (op)
			OP_INSERT: begin
				if (pos_x > cnt_x)
					chk_d = ST_RANGE;
				else if (cnt_x >= CW'(CAPACITY))
					chk_d = ST_FULL;
				else
					chk_d = ST_OK;
			end
			OP_GET, OP_REMOVE: begin
				if (cnt_q == '0)
					chk_d = ST_EMPTY;
				else if (pos_x >= cnt_x)
					chk_d = ST_RANGE;
				else
					chk_d = ST_OK;
			end
			OP_ROT_FWD, OP_ROT_BWD: begin
				chk_d  = ST_OK;
				fwd_d  = (op == OP_ROT_FWD);
				dist_d = (cnt_q == '0) ? '0 : CW'(steps);
			end
			default: chk_d = ST_RANGE;
		endcase
	end

	assign link_sel  = fwd_q ? nx_rd_q : pv_rd_q;
	assign n_slot    = SLOT_W'(cnt_q);
	assign last_m1   = SLOT_W'(cnt_q - CNT_W'(1));
	assign last_slot = n_slot;
	assign h1        = (cur_q == head_q) ? nx_rd_q : head_q;
	assign nl_d      = (cur_q == last_slot) ? cur_q : nx_rd_q;
	assign pl_d      = (cur_q == last_slot) ? cur_q : pv_rd_q;

	// memory port control per command
	always_comb begin
		rd_en = 1'b0;
		ra    = cur_q;
		el_we = 1'b0; el_wa = n_slot; el_wd = val_q;
		nx_we = 1'b0; nx_wa = n_slot; nx_wd = n_slot;
		pv_we = 1'b0; pv_wa = n_slot; pv_wd = n_slot;
		case (cmd)
			CMD_WALK_INIT: begin rd_en = 1'b1; ra = head_q; end
			CMD_WALK_STEP: begin rd_en = 1'b1; ra = link_sel; end
			CMD_RD_CUR:    begin rd_en = 1'b1; ra = cur_q; end
			CMD_REM_B:     begin rd_en = 1'b1; ra = last_slot; end
			CMD_INS_EMPTY: begin
				el_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
			end
			CMD_INS_A: begin
				el_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
				nx_wd = cur_q; pv_wd = pv_rd_q;
			end
			CMD_INS_B: begin
				nx_we = 1'b1; nx_wa = p_q;
				pv_we = 1'b1; pv_wa = cur_q;
			end
			CMD_REM_A: begin
				nx_we = 1'b1; nx_wa = pv_rd_q; nx_wd = nx_rd_q;
				pv_we = 1'b1; pv_wa = nx_rd_q; pv_wd = pv_rd_q;
			end
			CMD_REM_C: begin
				el_we = 1'b1; el_wa = cur_q; el_wd = el_rd_q;
				nx_we = 1'b1; nx_wa = cur_q; nx_wd = nl_d;
				pv_we = 1'b1; pv_wa = cur_q; pv_wd = pl_d;
			end
			CMD_REM_D: begin
				pv_we = 1'b1; pv_wa = nl_q; pv_wd = cur_q;
				nx_we = 1'b1; nx_wa = pl_q; nx_wd = cur_q;
			end
			default: ;
		endcase
	end

	// memories with registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			el_rd_q <= el_mem[ra];
			nx_rd_q <= nx_mem[ra];
			pv_rd_q <= pv_mem[ra];
		end
		if (el_we) el_mem[el_wa] <= el_wd;
		if (nx_we) nx_mem[nx_wa] <= nx_wd;
		if (pv_we) pv_mem[pv_wa] <= pv_wd;
	end

	// list control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			case (cmd)
				CMD_INS_EMPTY, CMD_INS_B: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (pos_zero_q) head_q <= n_slot;
				end
				CMD_REM_A: begin
					cnt_q  <= cnt_q - CNT_W'(1);
					head_q <= (h1 == last_m1) ? cur_q : h1;
				end
				CMD_ROT: head_q <= cur_q;
				default: ;
			endcase
		end
	end

	// item, walk and result registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q       <= op;
				pos_zero_q <= (position == '0);
				val_q      <= DATA_WIDTH'(value);
				chk_q      <= chk_d;
				dist_q     <= dist_d;
				fwd_q      <= fwd_d;
				res_q      <= '0;
			end
			CMD_WALK_INIT: begin
				cur_q <= head_q;
				rem_q <= dist_q;
			end
			CMD_WALK_STEP: begin
				cur_q <= link_sel;
				rem_q <= rem_q - CW'(1);
			end
			CMD_GET:   res_q <= el_rd_q;
			CMD_INS_A: p_q <= pv_rd_q;
			CMD_REM_A: res_q <= el_rd_q;
			CMD_REM_C: begin
				nl_q <= nl_d;
				pl_q <= pl_d;
			end
			CMD_FINISH: begin
				data     <= 32'(res_q);
				status   <= chk_q;
				count    <= 9'(cnt_q);
				is_empty <= (cnt_q == '0);
				is_full  <= (cnt_q == CNT_W'(CAPACITY));
			end
			default: ;
		endcase
	end

	// status towards the controller
	assign sts.chk_ok    = (chk_q == ST_OK);
	assign sts.op        = op_q;
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.dist_zero = (dist_q == '0);
	assign sts.rem_last  = (rem_q == CW'(1));

	`include "assert_macros.svh"

	`ALE_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY))
	`ALE_ASSERT(a_walk_rem, !(cmd == CMD_WALK_STEP && rem_q == '0))
	`ALE_ASSERT_NEXT(a_rem_count, cmd == CMD_REM_A, cnt_q == $past(cnt_q) - CNT_W'(1))

endmodule

### design/array_linked_list_engine.sv
// top level of the array backed circular doubly linked list engine
// One item is handled at a time. A rejected item goes from its check to the finish;
// a get walks and reads the slot; an insert walks, reads, writes the new slot and
// links it in (an empty list is written directly); a remove walks, reads, unlinks,
// then moves the last slot into the freed one; a rotate walks and moves the head.
// The walk steps one link per cycle from the head, the shorter way for get, insert
// and remove, the given way for rotate, paced by the registered link memory read.
// A result waits in an output register while the next item may be taken.
module array_linked_list_engine
	import ale_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [8:0]  position,
	input  logic [31:0] value,
	input  logic [7:0]  steps,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] data,
	output logic [1:0]  status,
	output logic [8:0]  count,
	output logic        is_empty,
	output logic        is_full
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	ale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and arithmetic
	ale_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.op       (op),
		.position (position),
		.value    (value),
		.steps    (steps),
		.data     (data),
		.status   (status),
		.count    (count),
		.is_empty (is_empty),
		.is_full  (is_full)
	);

endmodule
